// ===== design/tdbd_pkg.sv =====
// ----------------------------------------------------------------------------
// tdbd_pkg: shared types and constants of the table-driven block decryptor
// Holds the round count, the item record that travels down the round
// pipeline, the result record and the byte position map of shifted rounds.
// ----------------------------------------------------------------------------
`default_nettype none

package tdbd_pkg;

  // Number of rounds; the table index layout supports 3 to 32.
  localparam int ROUNDS = 17;

  // Field widths fixed by the item format.
  localparam int IDX_W   = 17;
  localparam int RND_W   = IDX_W - 12;
  localparam int WORD_W  = 32;
  localparam int BLOCK_W = 128;

  // Function codes carried in the input tuser field.
  typedef enum logic [1:0] {
    FUNC_LOAD_TABLE = 2'd0,
    FUNC_LOAD_KEY   = 2'd1,
    FUNC_DECRYPT    = 2'd2
  } func_t;

  // One word in flight through the rounds: a load or a block.
  typedef struct packed {
    logic                vld;
    func_t               func;
    logic [IDX_W-1:0]    idx;
    logic [WORD_W-1:0]   word;
    logic [BLOCK_W-1:0]  st;
    logic                last;
  } item_t;

  // One decrypted block on its way to the output port.
  typedef struct packed {
    logic [BLOCK_W-1:0]  data;
    logic                last;
  } res_t;

  // Byte positions feeding words 0..3 in a shifted round, four per word.
  localparam logic [3:0] SHIFT_POS [16] = '{
    4'd0, 4'd7, 4'd10, 4'd13,
    4'd1, 4'd4, 4'd11, 4'd14,
    4'd2, 4'd5, 4'd8,  4'd15,
    4'd3, 4'd6, 4'd9,  4'd12
  };

endpackage

`default_nettype wire

// ===== design/tdbd_lut.sv =====
// ----------------------------------------------------------------------------
// tdbd_lut: one 256 x 32 lookup table of a round
// Single write port for table loads and one registered read port that
// holds its data while the pipeline is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module tdbd_lut (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic        we,
  input  wire logic [7:0]  waddr,
  input  wire logic [31:0] wdata,
  input  wire logic [7:0]  raddr,
  output logic      [31:0] rdata
);

  logic [31:0] mem [256];
  logic [31:0] rdata_r;

  // Write on a table load, read for the word in the lookup stage.
  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[waddr] <= wdata;
    end
    if (en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/tdbd_round.sv =====
// ----------------------------------------------------------------------------
// tdbd_round: one decryption round as two pipeline stages
// Stage one looks up the sixteen state bytes in the round's tables; stage
// two XORs four lookups and a subkey word into each output word. Loads
// passing through write this round's tables and subkeys in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tdbd_round (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             en,
  input  wire logic [tdbd_pkg::RND_W-1:0]       round_id,
  input  wire tdbd_pkg::item_t                  in_item,
  output tdbd_pkg::item_t                       out_item
);

  tdbd_pkg::item_t mid_r;
  tdbd_pkg::item_t out_r;
  tdbd_pkg::item_t out_nxt;
  logic [31:0]     lut_q [16];
  logic [31:0]     key_r [4];
  logic            tab_we;
  logic            key_we;
  logic            shifted;

  // A table load for this round addresses one of the sixteen tables.
  assign tab_we = in_item.vld && (in_item.func == tdbd_pkg::FUNC_LOAD_TABLE) &&
                  (in_item.idx[tdbd_pkg::IDX_W-1:12] == round_id);

  // Lookup stage: one table per byte position.
  for (genvar p = 0; p < 16; p++) begin : g_lut
    tdbd_lut u_lut (
      .clk   (clk),
      .en    (en),
      .we    (tab_we && (in_item.idx[11:8] == 4'(p))),
      .waddr (in_item.idx[7:0]),
      .wdata (in_item.word),
      .raddr (in_item.st[8*p +: 8]),
      .rdata (lut_q[p])
    );
  end

  // The item moves along beside the table read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r <= '0;
    end else if (en) begin
      mid_r <= in_item;
    end
  end

  // Subkey words are written where they are used.
  assign key_we = mid_r.vld && (mid_r.func == tdbd_pkg::FUNC_LOAD_KEY) &&
                  (mid_r.idx[tdbd_pkg::IDX_W-1:2] == (tdbd_pkg::IDX_W-2)'(round_id));

  always_ff @(posedge clk) begin
    if (en && key_we) begin
      key_r[mid_r.idx[1:0]] <= mid_r.word;
    end
  end

  // The first two and the last round combine bytes straight.
  assign shifted = (int'(round_id) >= 2) && (int'(round_id) + 1 < tdbd_pkg::ROUNDS);

  // Combine stage: each word is four lookups XOR a subkey word.
  always_comb begin
    logic [31:0] acc;
    logic [3:0]  pos;
    out_nxt = mid_r;
    for (int k = 0; k < 4; k++) begin
      acc = key_r[k];
      for (int j = 0; j < 4; j++) begin
        pos = shifted ? tdbd_pkg::SHIFT_POS[4*k + j] : 4'(4*k + j);
        acc = acc ^ lut_q[pos];
      end
      if (mid_r.func == tdbd_pkg::FUNC_DECRYPT) begin
        out_nxt.st[32*k +: 32] = acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r <= '0;
    end else if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_item = out_r;

endmodule

`default_nettype wire

// ===== design/tdbd_skid.sv =====
// ----------------------------------------------------------------------------
// tdbd_skid: output register with a skid stage
// Holds the result word for the receiver and catches one more word when
// the receiver stalls; the pipeline halts only while the skid stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module tdbd_skid (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             pipe_vld,
  input  wire tdbd_pkg::res_t   pipe_res,
  output logic                  pipe_en,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output tdbd_pkg::res_t        out_res
);

  logic           main_vld_r;
  tdbd_pkg::res_t main_r;
  logic           skid_vld_r;
  tdbd_pkg::res_t skid_r;
  logic           take;

  // The pipeline runs whenever the skid stage is free.
  assign pipe_en = !skid_vld_r;
  assign take    = pipe_en && pipe_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (main_vld_r && !out_tready) begin
      // Receiver stalls: a new word parks in the skid stage.
      if (take) begin
        skid_vld_r <= 1'b1;
        skid_r     <= pipe_res;
      end
    end else if (skid_vld_r) begin
      main_vld_r <= 1'b1;
      main_r     <= skid_r;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= take;
      main_r     <= pipe_res;
    end
  end

  assign out_tvalid = main_vld_r;
  assign out_res    = main_r;

  // The skid stage is only used behind a waiting output word.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> main_vld_r)
    else $error("skid word held without an output word");

  // A word arriving during a stall lands in the skid stage.
  a_stall_catch: assert property (@(posedge clk) disable iff (!rst_n)
    (main_vld_r && !out_tready && !skid_vld_r && pipe_vld) |=> skid_vld_r)
    else $error("word lost during output stall");

  // A taken output word drains the skid stage.
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_vld_r && out_tready) |=> (!skid_vld_r && main_vld_r))
    else $error("skid stage did not drain");

endmodule

`default_nettype wire

// ===== design/table_driven_block_decryptor.sv =====
// ----------------------------------------------------------------------------
// table_driven_block_decryptor: pipelined 16-byte block decryptor
// Usage: in_tuser carries the function (load table word, load subkey word,
// decrypt block); in_tdata carries load index, load word and the 16-byte
// ciphertext; in_tlast marks the last block of a message and comes back on
// out_tlast. Each decrypt word gives one word on the out_ channel with the
// plaintext in out_tdata; loads and unused function codes give nothing.
// Loads travel down the pipeline in order with blocks, so a block sees
// exactly the tables and subkeys loaded before it was accepted.
// Throughput: one word per cycle while the receiver does not stall. Every
// round is two stages (table read, XOR combine); a block passes through
// the input register, the round stages and the output register in order.
// The tables are per-round, per-byte-position 256-entry memories with one
// registered read port each; that read sets the stage split.
// Reset clears all valid bits; tables and subkeys hold nothing defined
// until loaded. When the receiver stalls, one more result is caught in a
// skid stage and then the whole pipeline holds; in_tready drops until the
// skid stage drains, and nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module table_driven_block_decryptor (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [16:0] load_index, [48:17] load_word, [112:49] block_lo,
  // [176:113] block_hi, [183:177] zero
  input  wire logic [183:0] in_tdata,
  // [1:0] func
  input  wire logic [1:0]   in_tuser,
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [63:0] plain_lo, [127:64] plain_hi
  output logic      [127:0] out_tdata,
  output logic              out_tlast
);

  tdbd_pkg::item_t stage [tdbd_pkg::ROUNDS+1];
  tdbd_pkg::item_t in_r;
  tdbd_pkg::item_t in_nxt;
  tdbd_pkg::func_t in_func;
  tdbd_pkg::res_t  pipe_res;
  tdbd_pkg::res_t  out_res;
  logic            en;
  logic            fire;
  logic            pipe_vld;

  assign in_tready = en;
  assign fire      = in_tvalid && in_tready;
  assign in_func   = tdbd_pkg::func_t'(in_tuser);

  // Input stage: unpack the word; unused function codes drop out here.
  always_comb begin
    in_nxt.vld  = fire && ((in_func == tdbd_pkg::FUNC_LOAD_TABLE) ||
                           (in_func == tdbd_pkg::FUNC_LOAD_KEY) ||
                           (in_func == tdbd_pkg::FUNC_DECRYPT));
    in_nxt.func = in_func;
    in_nxt.idx  = in_tdata[16:0];
    in_nxt.word = in_tdata[48:17];
    in_nxt.st   = in_tdata[176:49];
    in_nxt.last = in_tlast;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_r <= '0;
    end else if (en) begin
      in_r <= in_nxt;
    end
  end

  assign stage[0] = in_r;

  // Round pipeline.
  for (genvar g = 0; g < tdbd_pkg::ROUNDS; g++) begin : g_round
    tdbd_round u_round (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .round_id (tdbd_pkg::RND_W'(g)),
      .in_item  (stage[g]),
      .out_item (stage[g+1])
    );
  end

  // Only decrypted blocks become results.
  assign pipe_vld      = stage[tdbd_pkg::ROUNDS].vld &&
                         (stage[tdbd_pkg::ROUNDS].func == tdbd_pkg::FUNC_DECRYPT);
  assign pipe_res.data = stage[tdbd_pkg::ROUNDS].st;
  assign pipe_res.last = stage[tdbd_pkg::ROUNDS].last;

  tdbd_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .pipe_vld   (pipe_vld),
    .pipe_res   (pipe_res),
    .pipe_en    (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = out_res.data;
  assign out_tlast = out_res.last;

endmodule

`default_nettype wire
